>>> src/tpd_pkg.sv
// Shared types and constants for the TGA pixel stream decoder.
package tpd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int PAL_LANES     = 3;

    localparam logic [2:0] FMT_INDEXED = 3'd0;
    localparam logic [2:0] FMT_GREY    = 3'd1;
    localparam logic [2:0] FMT_RGB555  = 3'd2;
    localparam logic [2:0] FMT_BGR24   = 3'd3;
    localparam logic [2:0] FMT_BGRA32  = 3'd4;

    localparam logic [2:0] CFG_PIXEL_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_RLE_ENABLE     = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_PALETTE_LENGTH = 3'd4;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic        rle_enable;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [8:0]  palette_length;
    } cfg_t;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic [1:0]            lane;
        logic [7:0]            data;
    } pal_wr_t;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic                  ok;
    } pal_rd_t;

    typedef struct packed {
        logic        emit;
        logic        indexed;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [31:0] first_pixel_index;
        logic        image_done;
    } result_t;

endpackage

>>> src/tpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tpd_palette.sv
// Palette store: one RAM per color lane, with a fill count per lane so unloaded entries read as zero.
module tpd_palette import tpd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pal_wr_t     wr,
    input  pal_rd_t     rd,
    output logic [23:0] entry
);

    for (genvar l = 0; l < PAL_LANES; l++)
    begin : g_lane
        logic                lane_we;
        logic [7:0]          lane_q;
        logic [PAL_ADDR_W:0] fill_reg;
        logic                hit_reg;

        assign lane_we = wr.en && (wr.lane == 2'(l));

        tpd_ram #(
            .WIDTH(8),
            .DEPTH(PALETTE_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (lane_we),
            .waddr(wr.addr),
            .wdata(wr.data),
            .re   (rd.en),
            .raddr(rd.addr),
            .rdata(lane_q)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fill_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                if (lane_we && ({1'b0, wr.addr} >= fill_reg))
                begin
                    fill_reg <= {1'b0, wr.addr} + (PAL_ADDR_W+1)'(1);
                end
                if (rd.en)
                begin
                    hit_reg <= rd.ok && ({1'b0, rd.addr} < fill_reg);
                end
            end
        end

        assign entry[8*l +: 8] = lane_q & {8{hit_reg}};
    end

endmodule

>>> src/tpd_parser.sv
// Stream parser: palette load, packet headers, pixel assembly and BGRA conversion.
module tpd_parser import tpd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       image_start,
    output pal_wr_t    pal_wr,
    output pal_rd_t    pal_rd,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_PALETTE = 3'b001,
        PH_BETWEEN = 3'b010,
        PH_PACKET  = 3'b100
    } phase_t;

    localparam logic [8:0] PAL_DEPTH_L = 9'(PALETTE_DEPTH);

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    phase_t                phase_reg, phase_next, ph;
    logic [9:0]            pbc_reg, pbc_next, pbc;
    logic [PAL_ADDR_W-1:0] entry_reg, entry_next, ent;
    logic [1:0]            lane_reg, lane_next, lane;
    logic [31:0]           pb_reg, pb_next, pb;
    logic [1:0]            bip_reg, bip_next, bip;
    logic [7:0]            prem_reg, prem_next, prem;
    logic                  prun_reg, prun_next, prun;
    logic [31:0]           pdone_reg, pdone_next, pdone;
    logic [31:0]           total_reg;

    logic [8:0]  pal_len;
    logic [9:0]  pal_bytes;
    logic [32:0] diff;
    logic        finished;
    logic [31:0] merged;
    logic [2:0]  size;
    logic [7:0]  prem_base;
    logic        prun_base;
    logic [7:0]  rep;
    logic [7:0]  prem_after;
    logic [15:0] v555;

    assign ph    = image_start ? PH_PALETTE : phase_reg;
    assign pbc   = image_start ? '0 : pbc_reg;
    assign ent   = image_start ? '0 : entry_reg;
    assign lane  = image_start ? '0 : lane_reg;
    assign pb    = image_start ? '0 : pb_reg;
    assign bip   = image_start ? '0 : bip_reg;
    assign prem  = image_start ? '0 : prem_reg;
    assign prun  = image_start ? 1'b0 : prun_reg;
    assign pdone = image_start ? '0 : pdone_reg;

    assign pal_len   = (cfg.palette_length > PAL_DEPTH_L) ? PAL_DEPTH_L : cfg.palette_length;
    assign pal_bytes = {pal_len, 1'b0} + {1'b0, pal_len};
    assign diff      = {1'b0, total_reg} - {1'b0, pdone};
    assign finished  = diff[32] || (diff[31:0] == 32'd0);
    assign merged    = pb | ({24'd0, data_byte} << {bip, 3'b000});
    assign prem_base = (ph == PH_PACKET) ? prem : 8'd1;
    assign prun_base = (ph == PH_PACKET) ? prun : 1'b0;
    assign v555      = merged[15:0];

    always_comb
    begin
        case (cfg.pixel_format)
            FMT_INDEXED: size = 3'd1;
            FMT_GREY:    size = 3'd1;
            FMT_RGB555:  size = 3'd2;
            FMT_BGRA32:  size = 3'd4;
            default:     size = 3'd3;
        endcase
    end

    always_comb
    begin
        phase_next = ph;
        pbc_next   = pbc;
        entry_next = ent;
        lane_next  = lane;
        pb_next    = pb;
        bip_next   = bip;
        prem_next  = prem;
        prun_next  = prun;
        pdone_next = pdone;
        pal_wr     = '0;
        pal_rd     = '0;
        result     = '0;
        rep        = 8'd1;
        prem_after = 8'd0;

        if (ph == PH_PALETTE && cfg.pixel_format == FMT_INDEXED && pbc < pal_bytes)
        begin
            pal_wr.en   = 1'b1;
            pal_wr.addr = ent;
            pal_wr.lane = lane;
            pal_wr.data = data_byte;
            pbc_next    = pbc + 10'd1;
            if (lane == 2'd2)
            begin
                lane_next  = 2'd0;
                entry_next = ent + PAL_ADDR_W'(1);
            end
            else
            begin
                lane_next = lane + 2'd1;
            end
        end
        else if (finished)
        begin
            if (ph == PH_PALETTE)
            begin
                phase_next = PH_BETWEEN;
            end
        end
        else if (ph != PH_PACKET && cfg.rle_enable)
        begin
            prem_next  = {1'b0, data_byte[6:0]} + 8'd1;
            prun_next  = data_byte[7];
            phase_next = PH_PACKET;
        end
        else
        begin
            prun_next = prun_base;
            if (({1'b0, bip} + 3'd1) < size)
            begin
                pb_next    = merged;
                bip_next   = bip + 2'd1;
                prem_next  = prem_base;
                phase_next = PH_PACKET;
            end
            else
            begin
                pb_next  = '0;
                bip_next = '0;
                if (prun_base)
                begin
                    if (diff[31:8] == 24'd0 && diff[7:0] < prem_base)
                    begin
                        rep = diff[7:0];
                    end
                    else
                    begin
                        rep = prem_base;
                    end
                    prem_after = 8'd0;
                end
                else
                begin
                    rep        = 8'd1;
                    prem_after = (prem_base != 8'd0) ? prem_base - 8'd1 : 8'd0;
                end
                prem_next  = prem_after;
                phase_next = (prem_after == 8'd0) ? PH_BETWEEN : PH_PACKET;
                pdone_next = pdone + {24'd0, rep};

                result.emit              = 1'b1;
                result.repeat_count      = rep;
                result.first_pixel_index = pdone;
                result.image_done        = ({24'd0, rep} == diff[31:0]);

                case (cfg.pixel_format)
                    FMT_INDEXED:
                    begin
                        result.indexed = 1'b1;
                        result.alpha   = 8'hFF;
                        pal_rd.en      = 1'b1;
                        pal_rd.addr    = merged[PAL_ADDR_W-1:0];
                        pal_rd.ok      = {1'b0, merged[7:0]} < PAL_DEPTH_L;
                    end
                    FMT_GREY:
                    begin
                        result.blue  = merged[7:0];
                        result.green = merged[7:0];
                        result.red   = merged[7:0];
                        result.alpha = merged[7:0];
                    end
                    FMT_RGB555:
                    begin
                        result.blue  = expand5(v555[4:0]);
                        result.green = expand5(v555[9:5]);
                        result.red   = expand5(v555[14:10]);
                        result.alpha = 8'hFF;
                    end
                    FMT_BGRA32:
                    begin
                        result.blue  = merged[7:0];
                        result.green = merged[15:8];
                        result.red   = merged[23:16];
                        result.alpha = merged[31:24];
                    end
                    default:
                    begin
                        result.blue  = merged[7:0];
                        result.green = merged[15:8];
                        result.red   = merged[23:16];
                        result.alpha = 8'hFF;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PALETTE;
            pbc_reg   <= '0;
            entry_reg <= '0;
            lane_reg  <= '0;
            pb_reg    <= '0;
            bip_reg   <= '0;
            prem_reg  <= '0;
            prun_reg  <= 1'b0;
            pdone_reg <= '0;
            total_reg <= 32'd1;
        end
        else
        begin
            total_reg <= 32'(cfg.image_width) * 32'(cfg.image_height);
            if (step)
            begin
                phase_reg <= phase_next;
                pbc_reg   <= pbc_next;
                entry_reg <= entry_next;
                lane_reg  <= lane_next;
                pb_reg    <= pb_next;
                bip_reg   <= bip_next;
                prem_reg  <= prem_next;
                prun_reg  <= prun_next;
                pdone_reg <= pdone_next;
            end
        end
    end

endmodule

>>> src/tga_pixel_stream_decoder_top.sv
// Top level of the TGA pixel stream decoder: config registers, item and result stages.
// Flow: a byte accepted into the item register is decoded into the result register when
// it steps (palette RAM read alongside); a held result stalls that step.
// Throughput: one byte per cycle unless a held result stalls; one more byte is taken while a result waits.
// Reset: counters and config return to defaults, palette fill counts clear at once so
// unloaded palette entries read as zero; no clearing pass.
module tga_pixel_stream_decoder_top import tpd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        image_start,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [7:0]  alpha,
    output logic [7:0]  repeat_count,
    output logic [31:0] first_pixel_index,
    output logic        image_done
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    result;
    pal_wr_t    pal_wr;
    pal_rd_t    pal_rd;
    logic [23:0] pal_entry;
    logic       advance;
    logic       step;
    logic       accept;

    assign cfg_ready  = 1'b1;
    assign advance    = !res_valid_reg || !pixel_stall;
    assign step       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format   <= FMT_BGR24;
            cfg_reg.rle_enable     <= 1'b0;
            cfg_reg.image_width    <= 16'd1;
            cfg_reg.image_height   <= 16'd1;
            cfg_reg.palette_length <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_FORMAT:   cfg_reg.pixel_format   <= cfg_data[2:0];
                CFG_RLE_ENABLE:     cfg_reg.rle_enable     <= cfg_data[0];
                CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data;
                CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data;
                CFG_PALETTE_LENGTH: cfg_reg.palette_length <= cfg_data[8:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= step && result.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= image_start;
        end
        if (step && result.emit)
        begin
            res_reg <= result;
        end
    end

    tpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .step       (step),
        .data_byte  (in_byte_reg),
        .image_start(in_start_reg),
        .pal_wr     (pal_wr),
        .pal_rd     (pal_rd),
        .result     (result)
    );

    tpd_palette u_palette (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (step ? pal_wr : '0),
        .rd   (step ? pal_rd : '0),
        .entry(pal_entry)
    );

    assign pixel_valid       = res_valid_reg;
    assign blue              = res_reg.indexed ? pal_entry[7:0]   : res_reg.blue;
    assign green             = res_reg.indexed ? pal_entry[15:8]  : res_reg.green;
    assign red               = res_reg.indexed ? pal_entry[23:16] : res_reg.red;
    assign alpha             = res_reg.alpha;
    assign repeat_count      = res_reg.repeat_count;
    assign first_pixel_index = res_reg.first_pixel_index;
    assign image_done        = res_reg.image_done;

    a_no_read_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && pixel_stall) |-> !(step && pal_rd.en))
        else $error("palette read while a result is held");

    a_no_write_with_read: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(pal_wr.en && pal_rd.en))
        else $error("palette write and read in one step");

    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.emit) |=> (pixel_valid && repeat_count != 8'd0
            && repeat_count <= 8'd128))
        else $error("result repeat count out of range");

endmodule
